// ----- design/noseg_pkg.sv -----
`default_nettype none

package noseg_pkg;

    localparam int unsigned TIME_W      = 32;
    localparam int unsigned PITCH_W     = 7;
    localparam int unsigned ENERGY_W    = 7;
    localparam int unsigned MIN_DUR_W   = 16;
    localparam int unsigned RISE_W      = 8;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned IN_TDATA_W  = 48;
    localparam int unsigned OUT_TDATA_W = 160;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN_DUR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_RISE    = 1'b1;

    localparam logic [MIN_DUR_W-1:0] MIN_DUR_RESET = 16'd50;
    localparam logic [RISE_W-1:0]    RISE_RESET    = 8'd40;
    localparam logic [RISE_W:0]      PERCENT_BASE  = 9'd100;

    typedef enum logic [1:0] {
        PH_FALL  = 2'd0,
        PH_RISE  = 2'd1,
        PH_FOUND = 2'd2
    } phase_t;

    typedef struct packed {
        phase_t                phase;
        logic [ENERGY_W-1:0]   prev;
        logic [ENERGY_W-1:0]   min;
        logic [ENERGY_W-1:0]   max;
    } trend_t;

    // lowest bits last
    typedef struct packed {
        logic                  buffer_empty;
        logic [ENERGY_W-1:0]   energy;
        logic [PITCH_W-1:0]    pitch;
        logic [TIME_W-1:0]     now;
    } frame_t;

    typedef struct packed {
        logic [TIME_W-1:0]     last_offset;
        logic [TIME_W-1:0]     start_elapsed;
        logic [TIME_W-1:0]     start_delta_time;
        logic [ENERGY_W-1:0]   start_velocity;
        logic [PITCH_W-1:0]    start_pitch;
        logic                  start_valid;
        logic [ENERGY_W-1:0]   stop_peak_energy;
        logic [TIME_W-1:0]     stop_delta_time;
        logic [PITCH_W-1:0]    stop_pitch;
        logic                  stop_valid;
    } result_t;

    localparam int unsigned FRAME_W  = $bits(frame_t);
    localparam int unsigned RESULT_W = $bits(result_t);

endpackage

`default_nettype wire

// ----- design/noseg_trend.sv -----
`default_nettype none

module noseg_trend (
    input  wire noseg_pkg::trend_t                     cur,
    input  wire logic [noseg_pkg::ENERGY_W-1:0]        energy,
    input  wire logic [noseg_pkg::RISE_W-1:0]          rise_percent,
    output noseg_pkg::trend_t                          nxt
);
    import noseg_pkg::*;

    logic [15:0] scaled_energy;
    logic [15:0] threshold;
    logic        rise_hit;

    // energy > ((100 + rise) * min) / 100  <=>  100 * energy > (100 + rise) * min
    assign scaled_energy = 16'(energy) * 16'(PERCENT_BASE);
    assign threshold     = 16'(PERCENT_BASE + 9'(rise_percent)) * 16'(cur.min);
    assign rise_hit      = scaled_energy > threshold;

    always_comb
    begin
        nxt      = cur;
        nxt.prev = energy;
        unique case (cur.phase)
            PH_FALL:
            begin
                if (energy < cur.prev)
                begin
                    nxt.min   = energy;
                    nxt.phase = PH_RISE;
                end
                else
                begin
                    nxt.max = energy;
                end
            end
            PH_RISE:
            begin
                if (energy > cur.prev)
                begin
                    if (rise_hit)
                    begin
                        nxt.phase = PH_FOUND;
                    end
                end
                else
                begin
                    nxt.min = energy;
                end
            end
            default:
            begin
                nxt.phase = cur.phase;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/noseg_core.sv -----
`default_nettype none

module noseg_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  step,
    input  wire noseg_pkg::frame_t                     frame,
    input  wire logic [noseg_pkg::MIN_DUR_W-1:0]       min_note_duration,
    input  wire logic [noseg_pkg::RISE_W-1:0]          rise_percent,
    output noseg_pkg::result_t                         res
);
    import noseg_pkg::*;

    logic                  note_active_reg, note_active_next;
    logic [PITCH_W-1:0]    note_pitch_reg, note_pitch_next;
    logic [PITCH_W-1:0]    cand_pitch_reg, cand_pitch_next;
    logic [TIME_W-1:0]     cand_start_reg, cand_start_next;
    logic [TIME_W-1:0]     prev_frame_reg, prev_frame_next;
    logic [TIME_W-1:0]     last_event_reg, last_event_next;
    logic [TIME_W-1:0]     offset_reg, offset_next;
    trend_t                note_trend_reg, note_trend_next;
    trend_t                cand_trend_reg, cand_trend_next;

    trend_t                cand_upd;
    trend_t                note_upd;
    logic                  pitch_nz;
    logic                  same_cand;
    logic                  long_enough;
    logic                  do_start;
    logic                  do_stop;
    logic [TIME_W-1:0]     t_evt;
    logic [TIME_W-1:0]     delta;

    noseg_trend u_cand_trend (
        .cur          (cand_trend_reg),
        .energy       (frame.energy),
        .rise_percent (rise_percent),
        .nxt          (cand_upd)
    );

    noseg_trend u_note_trend (
        .cur          (note_trend_reg),
        .energy       (frame.energy),
        .rise_percent (rise_percent),
        .nxt          (note_upd)
    );

    assign pitch_nz    = frame.pitch != '0;
    assign same_cand   = frame.pitch == cand_pitch_reg;
    assign long_enough = (frame.now - cand_start_reg) > TIME_W'(min_note_duration);
    assign do_start    = pitch_nz && same_cand && long_enough &&
                         (!note_active_reg || (cand_pitch_reg != note_pitch_reg) ||
                          (note_trend_reg.phase >= PH_FOUND));
    assign do_stop     = note_active_reg && (do_start || !pitch_nz);
    assign t_evt       = do_start ? cand_start_reg : prev_frame_reg;
    assign delta       = t_evt - last_event_reg;

    always_comb
    begin
        note_active_next = note_active_reg;
        note_pitch_next  = note_pitch_reg;
        cand_pitch_next  = cand_pitch_reg;
        cand_start_next  = cand_start_reg;
        cand_trend_next  = cand_trend_reg;
        last_event_next  = last_event_reg;
        offset_next      = note_active_reg ? frame.now : offset_reg;
        prev_frame_next  = frame.now;

        if (pitch_nz)
        begin
            if (same_cand)
            begin
                cand_trend_next = cand_upd;
            end
            else
            begin
                cand_start_next       = prev_frame_reg;
                cand_pitch_next       = frame.pitch;
                cand_trend_next.prev  = '0;
                cand_trend_next.phase = PH_FALL;
            end
        end
        else if (note_active_reg)
        begin
            cand_pitch_next = '0;
        end

        if (do_stop || do_start)
        begin
            last_event_next = t_evt;
        end

        if (do_start)
        begin
            note_active_next = 1'b1;
            note_pitch_next  = frame.pitch;
            offset_next      = frame.now;
        end
        else if (do_stop)
        begin
            note_active_next = 1'b0;
            offset_next      = t_evt;
        end

        // a start copies the candidate trend and updates it once more with the same energy
        if (do_start)
        begin
            note_trend_next      = cand_upd;
            note_trend_next.prev = frame.energy;
            unique case (cand_upd.phase)
                PH_FALL:
                begin
                    note_trend_next.max = frame.energy;
                end
                PH_RISE:
                begin
                    note_trend_next.min = frame.energy;
                end
                default:
                begin
                    note_trend_next.phase = cand_upd.phase;
                end
            endcase
        end
        else if (note_active_next)
        begin
            note_trend_next = note_upd;
        end
        else
        begin
            note_trend_next      = note_trend_reg;
            note_trend_next.prev = pitch_nz ? frame.energy : '0;
        end
    end

    always_comb
    begin
        res                  = '0;
        res.last_offset      = offset_next;
        if (do_stop)
        begin
            res.stop_valid       = 1'b1;
            res.stop_pitch       = note_pitch_reg;
            res.stop_delta_time  = delta;
            res.stop_peak_energy = note_trend_reg.max;
        end
        if (do_start)
        begin
            res.start_valid      = 1'b1;
            res.start_pitch      = frame.pitch;
            res.start_velocity   = frame.energy;
            res.start_delta_time = (frame.buffer_empty || do_stop) ? '0 : delta;
            res.start_elapsed    = frame.now - t_evt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            note_active_reg <= 1'b0;
            note_pitch_reg  <= '0;
            cand_pitch_reg  <= '0;
            cand_start_reg  <= '0;
            prev_frame_reg  <= '0;
            last_event_reg  <= '0;
            offset_reg      <= '0;
            note_trend_reg  <= '{phase: PH_FALL, prev: '0, min: '0, max: '0};
            cand_trend_reg  <= '{phase: PH_FALL, prev: '0, min: '0, max: '0};
        end
        else if (step)
        begin
            note_active_reg <= note_active_next;
            note_pitch_reg  <= note_pitch_next;
            cand_pitch_reg  <= cand_pitch_next;
            cand_start_reg  <= cand_start_next;
            prev_frame_reg  <= prev_frame_next;
            last_event_reg  <= last_event_next;
            offset_reg      <= offset_next;
            note_trend_reg  <= note_trend_next;
            cand_trend_reg  <= cand_trend_next;
        end
    end

`ifndef SYNTHESIS
    a_stop_needs_note: assert property (@(posedge clk) disable iff (!rst_n)
        step && do_stop |-> note_active_reg)
        else $error("stop without an active note");

    a_start_sets_note: assert property (@(posedge clk) disable iff (!rst_n)
        step && do_start |=> note_active_reg && note_pitch_reg == $past(frame.pitch))
        else $error("start did not record the note");

    a_stop_clears_note: assert property (@(posedge clk) disable iff (!rst_n)
        step && do_stop && !do_start |=> !note_active_reg && offset_reg == $past(t_evt))
        else $error("stop did not end the note");

    a_handover_zero_delta: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.stop_valid && res.start_valid |-> res.start_delta_time == '0)
        else $error("note handover with nonzero start delta");

    a_event_time: assert property (@(posedge clk) disable iff (!rst_n)
        step && (do_start || do_stop) |=> last_event_reg == $past(t_evt))
        else $error("event time not recorded");
`endif

endmodule

`default_nettype wire

// ----- design/note_onset_offset_segmenter.sv -----
`default_nettype none

// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  frame: now, pitch, energy, buffer_empty
// m_axis    out  m_axis_tvalid/m_axis_tready  result: stop and start reports, last offset
// cfg       in   cfg_we                       cfg_index, cfg_wdata
//
// One frame per cycle unless the result stalls; input register, then result register.
// A frame is processed in the cycle it moves from the input register to the
// result register; the state update of that cycle feeds the next frame.
// Reset clears the valid bits and core state and loads the defaults (50 ms, 40 percent).
// A stalled result holds; one more frame waits in the input register meanwhile.
module note_onset_offset_segmenter (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // now[31:0], pitch[38:32], energy[45:39], buffer_empty[46], zero[47]
    input  wire logic [noseg_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // stop_valid[0], stop_pitch[7:1], stop_delta_time[39:8], stop_peak_energy[46:40],
    // start_valid[47], start_pitch[54:48], start_velocity[61:55],
    // start_delta_time[93:62], start_elapsed[125:94], last_offset[157:126], zero[159:158]
    output logic [noseg_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    input  wire logic                                  cfg_we,
    input  wire logic [noseg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [noseg_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import noseg_pkg::*;

    logic                  in_vld_reg, in_vld_next;
    frame_t                in_frame_reg;
    logic                  out_vld_reg, out_vld_next;
    result_t               out_res_reg;
    logic [MIN_DUR_W-1:0]  min_dur_reg;
    logic [RISE_W-1:0]     rise_reg;

    logic                  advance;
    logic                  step;
    logic                  in_take;
    result_t               res;

    assign advance       = !out_vld_reg || m_axis_tready;
    assign step          = in_vld_reg && advance;
    assign s_axis_tready = !in_vld_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - RESULT_W)'(0), out_res_reg};

    noseg_core u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (step),
        .frame             (in_frame_reg),
        .min_note_duration (min_dur_reg),
        .rise_percent      (rise_reg),
        .res               (res)
    );

    always_comb
    begin
        in_vld_next  = in_take ? 1'b1 : (step ? 1'b0 : in_vld_reg);
        out_vld_next = step ? 1'b1 : (m_axis_tready ? 1'b0 : out_vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            min_dur_reg <= MIN_DUR_RESET;
            rise_reg    <= RISE_RESET;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_IDX_MIN_DUR: min_dur_reg <= cfg_wdata[MIN_DUR_W-1:0];
                    CFG_IDX_RISE:    rise_reg    <= cfg_wdata[RISE_W-1:0];
                    default:         rise_reg    <= rise_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_frame_reg <= frame_t'(s_axis_tdata[FRAME_W-1:0]);
        end
        if (step)
        begin
            out_res_reg <= res;
        end
    end

endmodule

`default_nettype wire
